@@ sv/kwc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwc_pkg
// Shared types, keyword table and constants for the keyword occurrence counter.
// ----------------------------------------------------------------------------
package kwc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int NUM_KW          = 14;
    localparam int KW_IDX_W        = $clog2(NUM_KW);
    localparam int KW_MAX_LEN      = 9;
    localparam int KW_LEN_W        = $clog2(KW_MAX_LEN + 1);
    localparam int HIST_DEPTH      = KW_MAX_LEN;
    localparam int GAP_W           = 4;
    localparam int BASE_W          = 24;
    localparam int B2_W            = 2 * BASE_W;
    localparam int ROOT_W          = 64;
    localparam int ROOT_STEPS      = ROOT_W / 2;
    localparam int ROOT_CNT_W      = $clog2(ROOT_STEPS);
    localparam int TOTAL_W         = 16;
    localparam int PEN_W           = 32;

    localparam logic [GAP_W-1:0] GAP_MAX   = 4'd15;
    localparam logic [GAP_W-1:0] GAP_RESET = 4'd12;

    localparam logic [KW_LEN_W-1:0] KW_LEN [NUM_KW] = '{
        4'd4, 4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd9, 4'd2, 4'd2, 4'd4, 4'd4, 4'd2
    };

    // keyword bytes in text order, zero padded
    localparam logic [7:0] KW_BYTES [NUM_KW][KW_MAX_LEN] = '{
        '{8'h66, 8'h75, 8'h63, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h73, 8'h68, 8'h69, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6E, 8'h69, 8'h67, 8'h67, 8'h65, 8'h72, 8'h00, 8'h00, 8'h00},
        '{8'h72, 8'h65, 8'h74, 8'h61, 8'h72, 8'h64, 8'h00, 8'h00, 8'h00},
        '{8'hE5, 8'h9E, 8'h83, 8'hE5, 8'h9C, 8'hBE, 8'h00, 8'h00, 8'h00},
        '{8'hE5, 8'h82, 8'hBB, 8'hE9, 8'h80, 8'hBC, 8'h00, 8'h00, 8'h00},
        '{8'hE6, 8'h93, 8'h8D, 8'hE4, 8'hBD, 8'hA0, 8'h00, 8'h00, 8'h00},
        '{8'hE5, 8'hA6, 8'h88, 8'hE7, 8'h9A, 8'h84, 8'h00, 8'h00, 8'h00},
        '{8'hE6, 8'hAD, 8'hBB, 8'hE5, 8'h85, 8'hA8, 8'hE5, 8'hAE, 8'hB6},
        '{8'h73, 8'h7A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6C, 8'h7A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h77, 8'h63, 8'h6E, 8'h6D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6E, 8'h6D, 8'h73, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h73, 8'h62, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } kwc_in_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] match_total;
        logic [PEN_W-1:0]   penalty_q8;
    } kwc_out_t;

    typedef enum logic [0:0] {
        M_IDLE,
        M_SCAN
    } kwc_mstate_t;

    typedef enum logic [2:0] {
        P_IDLE,
        P_SQUARE,
        P_MUL_LO,
        P_MUL_HI,
        P_ROOT,
        P_DONE
    } kwc_pstate_t;

    typedef struct packed {
        logic busy;
        logic fin;
    } kwc_mstat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } kwc_pstat_t;

    // j counts back from the newest byte
    function automatic logic [7:0] kw_rev_byte(input logic [KW_IDX_W-1:0] k,
                                               input logic [KW_LEN_W-1:0] j);
        logic [KW_LEN_W-1:0] idx;
        logic [7:0]          b;
        idx = KW_LEN[k] - j - 1'b1;
        b   = 8'h00;
        if (idx < KW_LEN_W'(KW_MAX_LEN))
        begin
            b = KW_BYTES[k][idx];
        end
        return b;
    endfunction

endpackage

@@ sv/kwc_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwc_matcher
// Byte history and keyword scan; one keyword checked per cycle by a shared
// comparator, with per-keyword gap tracking and a saturating running total.
// ----------------------------------------------------------------------------
module kwc_matcher #(
    parameter int COUNT_WIDTH = kwc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  kwc_pkg::kwc_in_t       beat,
    output kwc_pkg::kwc_mstat_t    stat,
    output logic [COUNT_WIDTH-1:0] total
);
    import kwc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [KW_IDX_W-1:0]    KW_LAST   = KW_IDX_W'(NUM_KW - 1);

    kwc_mstate_t            state_reg, state_next;
    logic [KW_IDX_W-1:0]    kw_reg, kw_next;
    logic                   last_reg, last_next;
    logic [7:0]             hist_reg [HIST_DEPTH];
    logic [7:0]             hist_next [HIST_DEPTH];
    logic [GAP_W-1:0]       gap_reg [NUM_KW];
    logic [GAP_W-1:0]       gap_next [NUM_KW];
    logic [COUNT_WIDTH-1:0] total_reg, total_next;

    logic [GAP_W-1:0]       gap_inc;
    logic                   hit;
    logic                   counted;
    logic [COUNT_WIDTH-1:0] total_inc;
    logic [7:0]             folded;

    assign folded = (beat.text_byte >= 8'h41 && beat.text_byte <= 8'h5A) ?
                    beat.text_byte + 8'h20 : beat.text_byte;

    always_comb
    begin
        hit = 1'b1;
        for (int j = 0; j < HIST_DEPTH; j++)
        begin
            if (KW_LEN_W'(j) < KW_LEN[kw_reg] &&
                hist_reg[j] != kw_rev_byte(kw_reg, KW_LEN_W'(j)))
            begin
                hit = 1'b0;
            end
        end
    end

    assign gap_inc   = (gap_reg[kw_reg] == GAP_MAX) ? GAP_MAX : gap_reg[kw_reg] + 1'b1;
    assign counted   = (state_reg == M_SCAN) && hit &&
                       (GAP_W'(KW_LEN[kw_reg]) <= gap_inc);
    assign total_inc = (total_reg == COUNT_MAX) ? total_reg : total_reg + 1'b1;
    assign total     = counted ? total_inc : total_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_SCAN;
                end
            end
            M_SCAN:
            begin
                if (kw_reg == KW_LAST)
                begin
                    state_next = M_IDLE;
                end
            end
            default: state_next = M_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        stat.busy = (state_reg == M_SCAN);
        stat.fin  = (state_reg == M_SCAN) && (kw_reg == KW_LAST) && last_reg;
    end

    // datapath
    always_comb
    begin
        hist_next  = hist_reg;
        gap_next   = gap_reg;
        total_next = total_reg;
        kw_next    = kw_reg;
        last_next  = last_reg;
        if (state_reg == M_IDLE && start)
        begin
            for (int i = HIST_DEPTH - 1; i > 0; i--)
            begin
                hist_next[i] = hist_reg[i-1];
            end
            hist_next[0] = folded;
            kw_next      = '0;
            last_next    = beat.last_byte;
        end
        else if (state_reg == M_SCAN)
        begin
            gap_next[kw_reg] = counted ? '0 : gap_inc;
            total_next       = total;
            kw_next          = (kw_reg == KW_LAST) ? '0 : kw_reg + 1'b1;
            if (kw_reg == KW_LAST && last_reg)
            begin
                for (int i = 0; i < HIST_DEPTH; i++)
                begin
                    hist_next[i] = 8'h00;
                end
                for (int k = 0; k < NUM_KW; k++)
                begin
                    gap_next[k] = GAP_RESET;
                end
                total_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            kw_reg    <= '0;
            last_reg  <= 1'b0;
            total_reg <= '0;
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= 8'h00;
            end
            for (int k = 0; k < NUM_KW; k++)
            begin
                gap_reg[k] <= GAP_RESET;
            end
        end
        else
        begin
            state_reg <= state_next;
            kw_reg    <= kw_next;
            last_reg  <= last_next;
            total_reg <= total_next;
            hist_reg  <= hist_next;
            gap_reg   <= gap_next;
        end
    end

endmodule

@@ sv/kwc_penalty.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwc_penalty
// Penalty unit: base^2 * total through one shared multiplier in three passes,
// then a bit-pair integer square root, one step per cycle, with saturation.
// ----------------------------------------------------------------------------
module kwc_penalty #(
    parameter int COUNT_WIDTH = kwc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [COUNT_WIDTH-1:0]      total,
    input  logic [kwc_pkg::BASE_W-1:0]  base,
    input  logic                        take,
    output kwc_pkg::kwc_pstat_t         stat,
    output logic [COUNT_WIDTH-1:0]      total_out,
    output logic [kwc_pkg::PEN_W-1:0]   penalty
);
    import kwc_pkg::*;

    localparam int MUL_BW = (COUNT_WIDTH > BASE_W) ? COUNT_WIDTH : BASE_W;
    localparam int MUL_PW = BASE_W + MUL_BW;
    localparam int PROD_W = B2_W + COUNT_WIDTH;
    localparam int EXT_W  = (PROD_W > ROOT_W) ? PROD_W : ROOT_W + 1;

    kwc_pstate_t            state_reg, state_next;
    logic [COUNT_WIDTH-1:0] tot_reg, tot_next;
    logic [B2_W-1:0]        b2_reg, b2_next;
    logic [PROD_W-1:0]      acc_reg, acc_next;
    logic [ROOT_W-1:0]      v_reg, v_next;
    logic [ROOT_W-1:0]      r_reg, r_next;
    logic [ROOT_W-1:0]      bit_reg, bit_next;
    logic [ROOT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                   over_reg, over_next;
    logic [PEN_W-1:0]       pen_reg, pen_next;

    logic [BASE_W-1:0]      mul_a;
    logic [MUL_BW-1:0]      mul_b;
    logic [MUL_PW-1:0]      prod;
    logic [PROD_W-1:0]      acc_sum;
    logic [EXT_W-1:0]       acc_ext;
    logic [ROOT_W-1:0]      trial;
    logic                   fits;

    assign prod    = mul_a * mul_b;
    assign acc_sum = acc_reg + (PROD_W'(prod) << BASE_W);
    assign acc_ext = EXT_W'(acc_sum);
    assign trial   = r_reg + bit_reg;
    assign fits    = v_reg >= trial;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    state_next = P_SQUARE;
                end
            end
            P_SQUARE: state_next = P_MUL_LO;
            P_MUL_LO: state_next = P_MUL_HI;
            P_MUL_HI: state_next = P_ROOT;
            P_ROOT:
            begin
                if (cnt_reg == ROOT_CNT_W'(ROOT_STEPS - 1))
                begin
                    state_next = P_DONE;
                end
            end
            P_DONE:
            begin
                if (take)
                begin
                    state_next = P_IDLE;
                end
            end
            default: state_next = P_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        stat.busy = (state_reg != P_IDLE);
        stat.done = (state_reg == P_DONE);
        total_out = tot_reg;
        penalty   = pen_reg;
    end

    // datapath
    always_comb
    begin
        tot_next  = tot_reg;
        b2_next   = b2_reg;
        acc_next  = acc_reg;
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        over_next = over_reg;
        pen_next  = pen_reg;
        mul_a     = b2_reg[BASE_W-1:0];
        mul_b     = MUL_BW'(tot_reg);
        unique case (state_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    tot_next = total;
                end
            end
            P_SQUARE:
            begin
                mul_a   = base;
                mul_b   = MUL_BW'(base);
                b2_next = prod[B2_W-1:0];
            end
            P_MUL_LO:
            begin
                acc_next = PROD_W'(prod);
            end
            P_MUL_HI:
            begin
                mul_a     = b2_reg[B2_W-1:BASE_W];
                v_next    = acc_ext[ROOT_W-1:0];
                over_next = |acc_ext[EXT_W-1:ROOT_W];
                r_next    = '0;
                bit_next  = ROOT_W'(1) << (ROOT_W - 2);
                cnt_next  = '0;
            end
            P_ROOT:
            begin
                if (fits)
                begin
                    v_next = v_reg - trial;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                pen_next = over_reg ? '1 : r_next[PEN_W-1:0];
            end
            P_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tot_reg  <= tot_next;
        b2_reg   <= b2_next;
        acc_reg  <= acc_next;
        v_reg    <= v_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        over_reg <= over_next;
        pen_reg  <= pen_next;
    end

endmodule

@@ sv/keyword_occurrence_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_occurrence_counter
// Counts non-overlapping keyword hits in a byte stream and reports the total
// with a square-root scaled penalty at the end of each transcript.
//
// Channels: in (one transcript byte plus last flag per beat), out (one beat
// per transcript: total and penalty), cfg (base penalty in Q16.8, write-only,
// always ready; write it only while the block is idle).
// Each input beat is accepted, then a single comparator checks one keyword
// per cycle through the whole keyword table; in_ready is low meanwhile.
// A beat marked last adds 3 multiplier passes and a 32-step square root; the
// result is then loaded into the output register once that register is free.
// The output register frees the input side: new bytes are taken while a
// result waits for out_ready. If the next transcript's result is ready first,
// it holds in the penalty unit and in_ready stays low until out_ready.
// Reset clears history, gaps, total, the output register and the base value.
// ----------------------------------------------------------------------------
module keyword_occurrence_counter #(
    parameter int COUNT_WIDTH = kwc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  kwc_pkg::kwc_in_t           in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output kwc_pkg::kwc_out_t          out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [kwc_pkg::BASE_W-1:0] cfg_data
);
    import kwc_pkg::*;

    kwc_mstat_t             mstat;
    kwc_pstat_t             pstat;
    logic [COUNT_WIDTH-1:0] scan_total;
    logic [COUNT_WIDTH-1:0] pen_total;
    logic [PEN_W-1:0]       pen_value;
    logic                   start;
    logic                   take;

    logic [BASE_W-1:0]      base_reg, base_next;
    logic                   out_valid_reg, out_valid_next;
    kwc_out_t               out_data_reg, out_data_next;

    assign in_ready  = !mstat.busy && !pstat.busy;
    assign start     = in_valid && in_ready;
    assign take      = pstat.done && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    kwc_matcher #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_matcher (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .beat  (in_data),
        .stat  (mstat),
        .total (scan_total)
    );

    kwc_penalty #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_penalty (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mstat.fin),
        .total     (scan_total),
        .base      (base_reg),
        .take      (take),
        .stat      (pstat),
        .total_out (pen_total),
        .penalty   (pen_value)
    );

    always_comb
    begin
        base_next      = cfg_valid ? cfg_data : base_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (take)
        begin
            out_valid_next            = 1'b1;
            out_data_next.match_total = TOTAL_W'(pen_total);
            out_data_next.penalty_q8  = pen_value;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

@@ sv/kwc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwc_checker
// Port-level checks for the keyword occurrence counter, bound to the top.
// ----------------------------------------------------------------------------
module kwc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input kwc_pkg::kwc_in_t           in_data,
    input logic                       out_valid,
    input logic                       out_ready,
    input kwc_pkg::kwc_out_t          out_data,
    input logic                       cfg_valid,
    input logic                       cfg_ready
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("out beat changed while stalled");

    // one byte in flight at a time
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after a beat");

    // a non-final byte never produces a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_data.last_byte && !out_valid |=> !out_valid)
        else $error("result after non-final byte");

    a_zero_pen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.match_total == '0 |-> out_data.penalty_q8 == '0)
        else $error("penalty without matches");

    // config writes are never stalled
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("cfg write stalled");

endmodule

bind keyword_occurrence_counter kwc_checker u_kwc_checker (.*);
